// ===== hdl/ddfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ddfd_pkg;

  // field widths
  localparam int unsigned VALUE_W = 27;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned DIGIT_W = 4;

  // a 27-bit value needs nine decimal digits
  localparam int unsigned BCD_DIGITS = 9;
  localparam int unsigned BCD_W      = BCD_DIGITS * DIGIT_W;

  // shift-and-add-3 conversion split over register stages
  localparam int unsigned STEPS_PER_STAGE = 7;
  localparam int unsigned NUM_STAGES =
    (VALUE_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // digit codes
  localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd15;
  localparam logic [DIGIT_W-1:0] ADJ_MIN    = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  // conversion state carried through the pipeline
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic [COUNT_W-1:0] count;
  } ddfd_work_t;

endpackage

`default_nettype wire

// ===== hdl/ddfd_dabble_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddfd_dabble_stage #(
  parameter int unsigned STEPS = 7
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  ddfd_pkg::ddfd_work_t data_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output ddfd_pkg::ddfd_work_t data_o
);
  import ddfd_pkg::*;

  ddfd_work_t step_d;
  ddfd_work_t data_q;
  logic       valid_q;

  // STEPS shift-and-add-3 steps, each adjusts all digits then shifts one bit in
  always_comb begin
    step_d = data_i;
    for (int s = 0; s < int'(STEPS); s++) begin
      for (int d = 0; d < int'(BCD_DIGITS); d++) begin
        if (step_d.bcd[d*DIGIT_W +: DIGIT_W] >= ADJ_MIN) begin
          step_d.bcd[d*DIGIT_W +: DIGIT_W] = step_d.bcd[d*DIGIT_W +: DIGIT_W] + ADJ_ADD;
        end
      end
      {step_d.bcd, step_d.bin} = {step_d.bcd, step_d.bin} << 1;
    end
  end

  // stage moves when empty or when the next stage takes its content
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= step_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hdl/ddfd_frame_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddfd_frame_ser #(
  parameter int unsigned DIGIT_SLOTS = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  valid_i,
  output logic                                 ready_o,
  input  ddfd_pkg::ddfd_work_t                 data_i,
  output logic                                 valid_o,
  input  wire                                  ready_i,
  output logic [ddfd_pkg::POS_W-1:0]           pos_o,
  output logic [ddfd_pkg::DIGIT_W-1:0]         code_o,
  output logic                                 last_o,
  output logic                                 ovf_o
);
  import ddfd_pkg::*;

  localparam int unsigned DIGS_W = DIGIT_SLOTS * DIGIT_W;

  logic                busy_q;
  logic [POS_W-1:0]    pos_q;
  logic [COUNT_W-1:0]  shown_q;
  logic [DIGS_W-1:0]   digits_q;
  logic                ovf_q;
  logic                last;
  logic                load;
  logic                advance;
  logic [COUNT_W-1:0]  shown_d;

  assign last    = (pos_q == POS_W'(DIGIT_SLOTS));
  assign advance = busy_q && ready_i;
  assign ready_o = !busy_q || (ready_i && last);
  assign load    = valid_i && ready_o;

  // digit counts past the frame count show every digit
  assign shown_d = (data_i.count > COUNT_W'(DIGIT_SLOTS)) ? COUNT_W'(DIGIT_SLOTS)
                                                          : data_i.count;

  // frame control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      pos_q  <= POS_W'(1);
    end else if (advance) begin
      if (last) begin
        busy_q <= 1'b0;
      end
      pos_q <= pos_q + POS_W'(1);
    end
  end

  // digits shift down one frame at a time
  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= data_i.bcd[DIGS_W-1:0];
      shown_q  <= shown_d;
      ovf_q    <= |data_i.bcd[BCD_W-1:DIGS_W];
    end else if (advance) begin
      digits_q <= digits_q >> DIGIT_W;
    end
  end

  assign valid_o = busy_q;
  assign pos_o   = pos_q;
  assign code_o  = (COUNT_W'(pos_q) <= shown_q) ? digits_q[DIGIT_W-1:0] : BLANK_CODE;
  assign last_o  = last;
  assign ovf_o   = last && ovf_q;

endmodule

`default_nettype wire

// ===== hdl/decimal_digit_frame_driver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                                         tlast       tuser
// s_axis    in   [26:0] value, [30:27] digit_count            -           -
// m_axis    out  [3:0] digit_position, [7:4] digit_code,      last_frame  overflow
//                [23:8] frame_word
//
// each input item yields DIGIT_SLOTS output transactions, one per cycle unless m_axis stalls
// the serializer loads a new item when idle or as the last frame of the one before is taken
// the binary to decimal conversion runs through four register stages, and the
// serializer registers the first frame after the last of them
// reset clears all valid state; a stall on m_axis holds the frame and backs up
// the conversion stages without losing or repeating anything

module decimal_digit_frame_driver #(
  parameter int unsigned DIGIT_SLOTS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // value[26:0], digit_count[30:27]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // digit_position[3:0], digit_code[7:4], frame_word[23:8]
  output logic        m_axis_tlast,   // last_frame
  output logic        m_axis_tuser    // overflow
);
  import ddfd_pkg::*;

  ddfd_work_t       chain_data  [NUM_STAGES+1];
  logic             chain_valid [NUM_STAGES+1];
  logic             chain_ready [NUM_STAGES+1];
  logic [POS_W-1:0]   pos;
  logic [DIGIT_W-1:0] code;

  // conversion input
  assign chain_data[0].bcd   = '0;
  assign chain_data[0].bin   = s_axis_tdata[VALUE_W-1:0];
  assign chain_data[0].count = s_axis_tdata[VALUE_W +: COUNT_W];
  assign chain_valid[0]      = s_axis_tvalid;
  assign s_axis_tready       = chain_ready[0];

  // conversion stages
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    localparam int unsigned STEPS = (g == NUM_STAGES - 1)
      ? VALUE_W - STEPS_PER_STAGE * (NUM_STAGES - 1) : STEPS_PER_STAGE;
    ddfd_dabble_stage #(.STEPS(STEPS)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // frame output
  ddfd_frame_ser #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[NUM_STAGES]),
    .ready_o (chain_ready[NUM_STAGES]),
    .data_i  (chain_data[NUM_STAGES]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pos_o   (pos),
    .code_o  (code),
    .last_o  (m_axis_tlast),
    .ovf_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'd0, pos, 4'd0, code, code, pos};

endmodule

`default_nettype wire

// ===== hdl/ddfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddfd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata,
  input wire        m_axis_tlast,
  input wire        m_axis_tuser
);
  import ddfd_pkg::*;

  // overflow only ever flagged on the closing frame
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("overflow outside last frame");

  // frame word repeats position and code
  a_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[23:8] == {4'd0, m_axis_tdata[3:0], 4'd0, m_axis_tdata[7:4]}))
    else $error("frame word mismatch");

  // code is a decimal digit or blank
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:4] <= 4'd9) || (m_axis_tdata[7:4] == BLANK_CODE))
    else $error("bad digit code");

  // frames of one item follow one another without gap
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
    else $error("frame sequence broken");

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled frame changed");

endmodule

bind decimal_digit_frame_driver ddfd_checker u_ddfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/decimal_digit_frame_driver_test.sv =====
`timescale 1ns / 1ps

module decimal_digit_frame_driver_test;
  import ddfd_pkg::*;

  localparam int unsigned DIGITS = 8;
  localparam int unsigned FIELD_ITEMS = 110;

  // one display-driver frame as it leaves the block
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [DIGIT_W-1:0] code;
    logic [15:0]        word;
    logic               last;
    logic               ovf;
  } digit_frame_t;

  // expected digit frames and their comparison against the output stream
  class digit_frame_book;
    digit_frame_t frames_due[$];
    int errors;
    int frames_checked;
    int overflow_frames;
    int numbers_taken;

    function new();
      errors = 0;
      frames_checked = 0;
      overflow_frames = 0;
      numbers_taken = 0;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // split an accepted number into its frames, least significant digit first
    function void note_number(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count);
      int unsigned rest;
      int unsigned shown;
      digit_frame_t f;
      rest = 32'(value);
      shown = (32'(count) > DIGITS) ? DIGITS : 32'(count);
      numbers_taken++;
      for (int unsigned pos = 1; pos <= DIGITS; pos++) begin
        f.position = pos[POS_W-1:0];
        f.code = (pos <= shown) ? DIGIT_W'(rest % 10) : BLANK_CODE;
        rest = rest / 10;
        f.word = {8'(f.position), 8'(f.code)};
        f.last = (pos == DIGITS);
        f.ovf = f.last && (rest != 0);
        frames_due.push_back(f);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // check one output transaction against the oldest expected frame
    function void check_frame(logic [23:0] tdata, logic tlast, logic tuser);
      digit_frame_t want;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none actual %0h last %0b ovf %0b",
                 $time, tdata, tlast, tuser);
        return;
      end
      want = frames_due.pop_front();
      frames_checked++;
      if (tuser === 1'b1) overflow_frames++;
      compare_field("digit_position", 16'(want.position), 16'(tdata[3:0]));
      compare_field("digit_code", 16'(want.code), 16'(tdata[7:4]));
      compare_field("frame_word", want.word, tdata[23:8]);
      compare_field("last_frame", 16'(want.last), 16'(tlast));
      compare_field("overflow", 16'(want.ovf), 16'(tuser));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  digit_frame_book book = new();

  decimal_digit_frame_driver #(
    .DIGIT_SLOTS(DIGITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      book.check_frame(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // present one number, with random idle cycles ahead of it
  task automatic send_number(input logic [VALUE_W-1:0] value,
                             input logic [COUNT_W-1:0] count);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, count, value};
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_number(value, count);
  endtask

  // hold off the sender until every frame has come out
  task automatic drain_frames();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  // random numbers, weighted toward small values and the eight-digit boundary
  task automatic random_numbers(input int n);
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        value = VALUE_W'($urandom_range(999));
      else if (pick < 45)
        value = VALUE_W'($urandom_range(100000050, 99999950));
      else
        value = VALUE_W'($urandom);
      if ($urandom_range(99) < 75)
        count = COUNT_W'($urandom_range(DIGITS, 1));
      else
        count = COUNT_W'($urandom);
      send_number(value, count);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, blanking, saturation, leading zeros, overflow edge
    send_number(27'd0, 4'd8);
    send_number(27'h7FFFFFF, 4'd8);
    send_number(27'd99999999, 4'd8);
    send_number(27'd100000000, 4'd8);
    send_number(27'd12345678, 4'd0);
    send_number(27'd123456789, 4'd0);
    send_number(27'd87654321, 4'd15);
    send_number(27'd87654321, 4'd9);
    send_number(27'd42, 4'd8);
    send_number(27'd7, 4'd1);
    send_number(27'd9876, 4'd2);
    send_number(27'd9876, 4'd3);
    send_number(27'd9876, 4'd4);
    send_number(27'd55555, 4'd5);
    send_number(27'd654321, 4'd6);
    send_number(27'd7654321, 4'd7);
    send_number(27'h5555555, 4'd10);
    send_number(27'h2AAAAAA, 4'd12);
    send_number(27'd99999999, 4'd14);
    send_number(27'd100000001, 4'd11);
    drain_frames();

    tx_idle_pct = 29;
    rx_idle_pct = 86;
    random_numbers(FIELD_ITEMS);
    drain_frames();

    tx_idle_pct = 86;
    rx_idle_pct = 29;
    random_numbers(FIELD_ITEMS);
    drain_frames();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_numbers(FIELD_ITEMS + 10);
    drain_frames();
    repeat (20) @(posedge clk_i);

    $display("numbers converted: %0d, digit frames checked: %0d, overflow flags seen: %0d",
             book.numbers_taken, book.frames_checked, book.overflow_frames);
    $display("covered blank and saturated digit counts, leading zeros and the 10^8 edge");
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timeout with %0d frames outstanding", book.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ddfd_pkg.sv
hdl/ddfd_dabble_stage.sv
hdl/ddfd_frame_ser.sv
hdl/decimal_digit_frame_driver.sv
hdl/ddfd_checker.sv
tb/decimal_digit_frame_driver_test.sv
